### rtl/mipsx_pkg.sv
// ----------------------------------------------------------------------------
// mipsx_pkg
// Shared codes and constants of the MIPS-I subset execute block.
// ----------------------------------------------------------------------------
package mipsx_pkg;

  localparam int unsigned NUM_REGS_DEF = 32;
  localparam int unsigned REG_IDX_W    = 5;
  localparam int unsigned WORD_W       = 32;

  localparam logic [WORD_W-1:0] BOOT_ADDRESS_RST = 32'hBFC0_0000;
  localparam logic [WORD_W-1:0] PC_REGION_MASK   = 32'hF000_0000;
  localparam int unsigned       ISOLATE_BIT      = 16;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'b000000;
  localparam logic [5:0] OP_J       = 6'b000010;
  localparam logic [5:0] OP_BNE     = 6'b000101;
  localparam logic [5:0] OP_ADDI    = 6'b001000;
  localparam logic [5:0] OP_ADDIU   = 6'b001001;
  localparam logic [5:0] OP_SLTI    = 6'b001010;
  localparam logic [5:0] OP_ORI     = 6'b001101;
  localparam logic [5:0] OP_LUI     = 6'b001111;
  localparam logic [5:0] OP_COP0    = 6'b010000;
  localparam logic [5:0] OP_LW      = 6'b100011;
  localparam logic [5:0] OP_SH      = 6'b101001;
  localparam logic [5:0] OP_SW      = 6'b101011;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL  = 6'b000000;
  localparam logic [5:0] FN_ADDU = 6'b100001;
  localparam logic [5:0] FN_OR   = 6'b100101;
  localparam logic [5:0] FN_NOR  = 6'b100111;
  localparam logic [5:0] FN_SLTU = 6'b101011;

  // coprocessor 0
  localparam logic [4:0] COP_MT     = 5'd4;
  localparam logic [4:0] CP0_SR     = 5'd12;
  localparam logic [4:0] CP0_BPC    = 5'd3;
  localparam logic [4:0] CP0_BDA    = 5'd5;
  localparam logic [4:0] CP0_JUMPD  = 5'd6;
  localparam logic [4:0] CP0_DCIC   = 5'd7;
  localparam logic [4:0] CP0_BDAM   = 5'd9;
  localparam logic [4:0] CP0_BPCM   = 5'd11;
  localparam logic [4:0] CP0_CAUSE  = 5'd13;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LW    = 2'd1,
    MEM_SW    = 2'd2,
    MEM_SH    = 2'd3
  } mem_kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_OP   = 2'd1,
    STAT_OVERFLOW = 2'd2,
    STAT_BAD_COP  = 2'd3
  } status_t;

endpackage

### rtl/mipsx_if.sv
// ----------------------------------------------------------------------------
// mipsx channel interfaces
// Valid/ready channels for instructions, results and the boot address write.
// ----------------------------------------------------------------------------
interface mipsx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic [31:0] load_data;

  modport source (output valid, output instr_word, output load_data, input ready);
  modport sink   (input valid, input instr_word, input load_data, output ready);
endinterface

interface mipsx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] fetch_address;
  logic [1:0]  mem_kind;
  logic [31:0] mem_address;
  logic [31:0] store_data;
  logic [1:0]  status;

  modport source (output valid, output fetch_address, output mem_kind,
                  output mem_address, output store_data, output status, input ready);
  modport sink   (input valid, input fetch_address, input mem_kind,
                  input mem_address, input store_data, input status, output ready);
endinterface

interface mipsx_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/mips_i_subset_execute_top.sv
// ----------------------------------------------------------------------------
// mips_i_subset_execute_top
// Executes one MIPS-I subset instruction per transfer and reports the next
// fetch address, one memory request and a status code. Throughput is one
// instruction per cycle while results are taken; each instruction is held
// in the input stage, read from the registered read port of the register
// file as it is taken in, and then in the result register. A load's data
// comes with the next instruction and is written to the register file as
// that instruction is taken. A boot address write reloads the pc if none commits.
// ----------------------------------------------------------------------------
module mips_i_subset_execute_top #(
  parameter int unsigned NUM_REGS = mipsx_pkg::NUM_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mipsx_in_if.sink    instr,
  mipsx_out_if.source result,
  mipsx_cfg_if.sink   cfg
);

  localparam int unsigned AW = $clog2(NUM_REGS);

  // register file: one write port, two registered read ports
  logic [31:0]         gpr [NUM_REGS];
  logic [NUM_REGS-1:0] gpr_vld;

  // input stage
  logic        s1_valid;
  logic [31:0] s1_instr;
  logic [31:0] rd_a, rd_b;
  logic        rd_a_vld, rd_b_vld;
  logic        fwd_a, fwd_b;
  logic [31:0] fwd_val;

  // architectural state
  logic [31:0]   pc;
  logic [31:0]   status_reg;
  logic          pend_valid;
  logic [AW-1:0] pend_tgt;

  // result register
  logic        out_valid;
  logic [31:0] out_fetch, out_addr, out_sdata;
  logic [1:0]  out_kind, out_stat;

  logic commit, accept;

  // decode of the held instruction
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, a, b, sum, pc_inc;
  logic        isolated;

  // execute results
  logic          wr;
  logic [AW-1:0] widx;
  logic [31:0]   wval;
  logic [1:0]    kind;
  logic [31:0]   addr, sdata;
  logic [1:0]    stat;
  logic [31:0]   pc_next, status_next;
  logic          ld_new;

  // load pending for the instruction being taken in
  logic          pend_eff;
  logic [AW-1:0] pend_eff_tgt;

  // register file write port
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          alu_we;

  assign commit      = s1_valid && (!out_valid || result.ready);
  assign instr.ready = !s1_valid || commit;
  assign accept      = instr.valid && instr.ready;
  assign cfg.ready   = 1'b1;

  assign op   = s1_instr[31:26];
  assign rs   = s1_instr[25:21];
  assign rt   = s1_instr[20:16];
  assign rd   = s1_instr[15:11];
  assign sh   = s1_instr[10:6];
  assign fn   = s1_instr[5:0];
  assign imm  = s1_instr[15:0];
  assign simm = {{16{imm[15]}}, imm};

  assign a = fwd_a ? fwd_val : (rd_a_vld ? rd_a : '0);
  assign b = fwd_b ? fwd_val : (rd_b_vld ? rd_b : '0);

  assign sum      = a + simm;
  assign pc_inc   = pc + 32'd4;
  assign isolated = status_reg[mipsx_pkg::ISOLATE_BIT];

  always_comb begin
    wr          = 1'b0;
    widx        = rd[AW-1:0];
    wval        = '0;
    kind        = mipsx_pkg::MEM_NONE;
    addr        = '0;
    sdata       = '0;
    stat        = mipsx_pkg::STAT_OK;
    pc_next     = pc_inc;
    status_next = status_reg;
    ld_new      = 1'b0;
    unique case (op)
      mipsx_pkg::OP_SPECIAL: begin
        wr = 1'b1;
        unique case (fn)
          mipsx_pkg::FN_SLL:  wval = b << sh;
          mipsx_pkg::FN_OR:   wval = a | b;
          mipsx_pkg::FN_NOR:  wval = ~(a | b);
          mipsx_pkg::FN_SLTU: wval = {31'd0, a < b};
          mipsx_pkg::FN_ADDU: wval = a + b;
          default: begin
            wr   = 1'b0;
            stat = mipsx_pkg::STAT_BAD_OP;
          end
        endcase
      end
      mipsx_pkg::OP_LUI: begin
        wr = 1'b1; widx = rt[AW-1:0]; wval = {imm, 16'd0};
      end
      mipsx_pkg::OP_ORI: begin
        wr = 1'b1; widx = rt[AW-1:0]; wval = a | {16'd0, imm};
      end
      mipsx_pkg::OP_SLTI: begin
        wr = 1'b1; widx = rt[AW-1:0]; wval = {31'd0, $signed(a) < $signed(simm)};
      end
      mipsx_pkg::OP_ADDIU: begin
        wr = 1'b1; widx = rt[AW-1:0]; wval = sum;
      end
      mipsx_pkg::OP_ADDI: begin
        // signed overflow: both operands differ in sign from the sum
        if (((a ^ sum) & (simm ^ sum)) >> 31 != 32'd0) begin
          stat = mipsx_pkg::STAT_OVERFLOW;
        end else begin
          wr = 1'b1; widx = rt[AW-1:0]; wval = sum;
        end
      end
      mipsx_pkg::OP_SW: begin
        if (!isolated) begin
          kind = mipsx_pkg::MEM_SW; addr = sum; sdata = b;
        end
      end
      mipsx_pkg::OP_SH: begin
        if (!isolated) begin
          kind = mipsx_pkg::MEM_SH; addr = sum; sdata = {16'd0, b[15:0]};
        end
      end
      mipsx_pkg::OP_LW: begin
        if (!isolated) begin
          kind = mipsx_pkg::MEM_LW; addr = sum; ld_new = 1'b1;
        end
      end
      mipsx_pkg::OP_J: begin
        pc_next = (pc_inc & mipsx_pkg::PC_REGION_MASK) | {4'd0, s1_instr[25:0], 2'b00};
      end
      mipsx_pkg::OP_BNE: begin
        // target is pc + 4 + (offset << 2) - 4
        if (a != b) pc_next = pc + {simm[29:0], 2'b00};
      end
      mipsx_pkg::OP_COP0: begin
        if (rs != mipsx_pkg::COP_MT) begin
          stat = mipsx_pkg::STAT_BAD_OP;
        end else if (rd == mipsx_pkg::CP0_SR) begin
          status_next = b;
        end else if ((rd == mipsx_pkg::CP0_BPC  || rd == mipsx_pkg::CP0_BDA  ||
                      rd == mipsx_pkg::CP0_JUMPD || rd == mipsx_pkg::CP0_DCIC ||
                      rd == mipsx_pkg::CP0_BDAM || rd == mipsx_pkg::CP0_BPCM ||
                      rd == mipsx_pkg::CP0_CAUSE) && b == 32'd0) begin
          stat = mipsx_pkg::STAT_OK;
        end else begin
          stat = mipsx_pkg::STAT_BAD_COP;
        end
      end
      default: stat = mipsx_pkg::STAT_BAD_OP;
    endcase
  end

  always_comb begin
    if (commit) begin
      pend_eff     = ld_new;
      pend_eff_tgt = rt[AW-1:0];
    end else begin
      pend_eff     = pend_valid;
      pend_eff_tgt = pend_tgt;
    end
  end

  // Load data is written as the delay-slot instruction is taken in. A commit
  // with a register write never coincides: then the committing item is a load.
  assign alu_we = commit && wr && (widx != '0);

  always_comb begin
    if (alu_we) begin
      we    = 1'b1;
      waddr = widx;
      wdata = wval;
    end else begin
      we    = accept && pend_eff && (pend_eff_tgt != '0);
      waddr = pend_eff_tgt;
      wdata = instr.load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) gpr[waddr] <= wdata;
    if (accept) begin
      rd_a <= gpr[instr.instr_word[21 +: AW]];
      rd_b <= gpr[instr.instr_word[16 +: AW]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gpr_vld <= '0;
    end else if (we) begin
      gpr_vld[waddr] <= 1'b1;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr <= instr.instr_word;
      rd_a_vld <= gpr_vld[instr.instr_word[21 +: AW]];
      rd_b_vld <= gpr_vld[instr.instr_word[16 +: AW]];
      fwd_a    <= alu_we && (widx == instr.instr_word[21 +: AW]);
      fwd_b    <= alu_we && (widx == instr.instr_word[16 +: AW]);
      fwd_val  <= wval;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= mipsx_pkg::BOOT_ADDRESS_RST;
      status_reg <= '0;
      pend_valid <= 1'b0;
      pend_tgt   <= '0;
    end else if (commit) begin
      pc         <= pc_next;
      status_reg <= status_next;
      pend_valid <= ld_new;
      pend_tgt   <= ld_new ? rt[AW-1:0] : '0;
    end else if (cfg.valid) begin
      pc <= cfg.data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_fetch <= pc;
      out_kind  <= kind;
      out_addr  <= addr;
      out_sdata <= sdata;
      out_stat  <= stat;
    end
  end

  assign result.valid         = out_valid;
  assign result.fetch_address = out_fetch;
  assign result.mem_kind      = out_kind;
  assign result.mem_address   = out_addr;
  assign result.store_data    = out_sdata;
  assign result.status        = out_stat;

endmodule

### rtl/mipsx_checker.sv
// ----------------------------------------------------------------------------
// mipsx_checker
// Port-level checks on the result channel of the execute block.
// ----------------------------------------------------------------------------
module mipsx_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] fetch_address,
  input logic [1:0]  mem_kind,
  input logic [31:0] mem_address,
  input logic [31:0] store_data,
  input logic [1:0]  status
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(fetch_address) && $stable(mem_address))
    else $error("result changed while stalled");

  a_no_request: assert property (@(posedge clk) disable iff (rst)
    out_valid && mem_kind == mipsx_pkg::MEM_NONE |-> mem_address == 32'd0 &&
    store_data == 32'd0)
    else $error("address or data without memory request");

  a_fault_no_mem: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mipsx_pkg::STAT_OK |-> mem_kind == mipsx_pkg::MEM_NONE)
    else $error("memory request on faulting instruction");

  a_load_halfword_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mem_kind == mipsx_pkg::MEM_LW ||
    (mem_kind == mipsx_pkg::MEM_SH && store_data[31:16] != 16'd0)) |->
    mem_kind == mipsx_pkg::MEM_LW && store_data == 32'd0)
    else $error("store data malformed for load or halfword store");

endmodule

bind mips_i_subset_execute_top mipsx_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .fetch_address (result.fetch_address),
  .mem_kind      (result.mem_kind),
  .mem_address   (result.mem_address),
  .store_data    (result.store_data),
  .status        (result.status)
);
